@@ rtl/ccl_pkg.sv @@
`timescale 1ns / 1ps
// ccl_pkg: shared types, codes and CRC helpers for the CRC-checked command link.
// Used by every module under rtl/; depends on nothing.
package ccl_pkg;

    localparam int CCL_MAX_CMD_BYTES = 16;
    // job length/index field, wide enough for buffers up to 63 bytes
    localparam int CCL_LEN_W         = 6;
    localparam int CCL_QUEUE_DEPTH   = 4;
    localparam int CCL_VALUE_BYTES   = 4;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  ACK_BYTE  = 8'hFF;
    localparam logic [7:0]  RETRY_RST = 8'd2;

    // input beat function codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_RX    = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    // read reply kinds
    localparam logic [1:0] KIND_ONE         = 2'd0;
    localparam logic [1:0] KIND_TWO         = 2'd1;
    localparam logic [1:0] KIND_FOUR        = 2'd2;
    localparam logic [1:0] KIND_FOUR_STATUS = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COLLECT,
        PH_ACK,
        PH_READ
    } phase_t;

    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_READ,
        JOB_REPLAY,
        JOB_DONE
    } job_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_FETCH,
        BK_SHOW
    } back_state_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [7:0] address;
        logic [7:0] command;
        logic [1:0] reply_kind;
    } in_beat_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        done_res;
        logic        success;
        logic [31:0] read_value;
        logic [7:0]  status_byte;
        logic        last;
    } out_beat_t;

    // one entry of the front-to-back queue
    typedef struct packed {
        job_kind_t            kind;
        logic [7:0]           byte_a;    // write byte / address
        logic [7:0]           byte_b;    // command
        logic                 with_crc;  // write: final byte, append CRC
        logic [15:0]          crc;
        logic [CCL_LEN_W-1:0] len;       // write: buffer index, replay: length
        logic                 ok;
        logic [31:0]          value;
        logic [7:0]           status;
    } job_t;

    // one byte through the MSB-first CRC-16; flattens to an XOR network
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [2:0] reply_len(input logic [1:0] kind);
        logic [2:0] n;
        unique case (kind)
            KIND_ONE:  n = 3'd1;
            KIND_TWO:  n = 3'd2;
            KIND_FOUR: n = 3'd4;
            default:   n = 3'd5;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/crc_checked_command_link.sv @@
`timescale 1ns / 1ps
// crc_checked_command_link: top level of the CRC-16 command link host side.
// Instantiates ccl_front, ccl_queue and ccl_back; depends on ccl_pkg.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+---------------------------
//   in      | into      | in_valid/in_stall  | in_data  (in_beat_t)
//   out     | out of    | out_valid/out_stall| out_data (out_beat_t)
//   cfg     | into      | cfg_wr_en          | cfg_wr_data (retry_limit)
//
// The front takes one input beat per cycle while the 4-entry job queue has room;
// in_stall is the queue-full flag.
// The back pops one job at a time in IDLE, then emits its fixed output beats from RUN
// (data, address, command, CRC bytes, completion); it pops another job only after the last beat.
// Each replayed buffer byte goes through FETCH (registered buffer read) and then SHOW,
// and the CRC bytes of the retry follow in RUN.
// Reset clears phase, CRC, counters and queue; retry_limit returns to 2.
// out_stall holds the output register; the queue absorbs input meanwhile.
module crc_checked_command_link #(
    parameter int MAX_CMD_BYTES = ccl_pkg::CCL_MAX_CMD_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ccl_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ccl_pkg::out_beat_t out_data,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data
);
    import ccl_pkg::*;

    logic   q_push;
    logic   q_full;
    job_t   push_job;
    job_t   head_job;
    logic   q_empty;
    logic   q_pop;

    ccl_front #(
        .MAX_CMD_BYTES(MAX_CMD_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    ccl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .full    (q_full),
        .push_job(push_job),
        .pop     (q_pop),
        .empty   (q_empty),
        .head    (head_job)
    );

    ccl_back #(
        .MAX_CMD_BYTES(MAX_CMD_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_head   (head_job),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule

@@ rtl/ccl_front.sv @@
`timescale 1ns / 1ps
// ccl_front: accepts input beats, tracks link phase, CRC and retries, and
// queues one job per beat that produces output. Depends on ccl_pkg.
module ccl_front #(
    parameter int MAX_CMD_BYTES = ccl_pkg::CCL_MAX_CMD_BYTES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  ccl_pkg::in_beat_t in_data,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             q_full,
    output logic             q_push,
    output ccl_pkg::job_t    q_job
);
    import ccl_pkg::*;

    localparam int LEN_W = $clog2(MAX_CMD_BYTES + 1);

    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [LEN_W-1:0] cmd_length_reg, cmd_length_next;
    logic [7:0]  tries_left_reg, tries_left_next;
    logic [1:0]  saved_kind_reg, saved_kind_next;
    logic [2:0]  rx_index_reg, rx_index_next;
    logic [31:0] value_accum_reg, value_accum_next;
    logic [7:0]  status_hold_reg, status_hold_next;
    logic [7:0]  saved_address_reg, saved_address_next;
    logic [7:0]  saved_command_reg, saved_command_next;
    logic [7:0]  crc_high_hold_reg, crc_high_hold_next;
    logic [7:0]  retry_limit_reg;

    logic             accept;
    logic [LEN_W-1:0] base_len;
    logic [15:0]      base_crc;
    logic [15:0]      fold_db;
    logic [15:0]      seed_new;
    logic [15:0]      seed_saved;
    logic [2:0]       n_bytes;
    logic [15:0]      crc_got;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // a write starting from idle begins with an empty buffer and zero CRC
    assign base_len   = (phase_reg == PH_IDLE) ? '0 : cmd_length_reg;
    assign base_crc   = (phase_reg == PH_IDLE) ? '0 : crc_reg;
    assign fold_db    = crc_fold(base_crc, in_data.data_byte);
    assign seed_new   = crc_fold(crc_fold('0, in_data.address), in_data.command);
    assign seed_saved = crc_fold(crc_fold('0, saved_address_reg), saved_command_reg);
    assign n_bytes    = reply_len(saved_kind_reg);
    assign crc_got    = {crc_high_hold_reg, in_data.data_byte};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_RST;
        end
        else if (cfg_wr_en)
        begin
            retry_limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            crc_reg           <= '0;
            cmd_length_reg    <= '0;
            tries_left_reg    <= '0;
            saved_kind_reg    <= '0;
            rx_index_reg      <= '0;
            value_accum_reg   <= '0;
            status_hold_reg   <= '0;
            saved_address_reg <= '0;
            saved_command_reg <= '0;
            crc_high_hold_reg <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            crc_reg           <= crc_next;
            cmd_length_reg    <= cmd_length_next;
            tries_left_reg    <= tries_left_next;
            saved_kind_reg    <= saved_kind_next;
            rx_index_reg      <= rx_index_next;
            value_accum_reg   <= value_accum_next;
            status_hold_reg   <= status_hold_next;
            saved_address_reg <= saved_address_next;
            saved_command_reg <= saved_command_next;
            crc_high_hold_reg <= crc_high_hold_next;
        end
    end

    always_comb begin
        phase_next         = phase_reg;
        crc_next           = crc_reg;
        cmd_length_next    = cmd_length_reg;
        tries_left_next    = tries_left_reg;
        saved_kind_next    = saved_kind_reg;
        rx_index_next      = rx_index_reg;
        value_accum_next   = value_accum_reg;
        status_hold_next   = status_hold_reg;
        saved_address_next = saved_address_reg;
        saved_command_next = saved_command_reg;
        crc_high_hold_next = crc_high_hold_reg;
        q_push             = 1'b0;
        q_job              = '0;

        if (accept)
        begin
            unique case (in_data.func)
                FUNC_WRITE:
                begin
                    if (phase_reg == PH_IDLE || phase_reg == PH_COLLECT)
                    begin
                        q_push = 1'b1;
                        if (base_len >= LEN_W'(MAX_CMD_BYTES))
                        begin
                            // overlong: drop byte, fail at once
                            q_job.kind      = JOB_DONE;
                            phase_next      = PH_IDLE;
                            cmd_length_next = '0;
                            crc_next        = base_crc;
                        end
                        else
                        begin
                            q_job.kind      = JOB_WRITE;
                            q_job.byte_a    = in_data.data_byte;
                            q_job.len       = CCL_LEN_W'(base_len);
                            q_job.with_crc  = in_data.last_byte;
                            q_job.crc       = fold_db;
                            cmd_length_next = base_len + 1'b1;
                            crc_next        = fold_db;
                            if (in_data.last_byte)
                            begin
                                tries_left_next = retry_limit_reg;
                                phase_next      = PH_ACK;
                            end
                            else
                            begin
                                phase_next = PH_COLLECT;
                            end
                        end
                    end
                end
                FUNC_READ:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        saved_address_next = in_data.address;
                        saved_command_next = in_data.command;
                        saved_kind_next    = in_data.reply_kind;
                        tries_left_next    = retry_limit_reg;
                        phase_next         = PH_READ;
                        crc_next           = seed_new;
                        rx_index_next      = '0;
                        value_accum_next   = '0;
                        status_hold_next   = '0;
                        q_push             = 1'b1;
                        q_job.kind         = JOB_READ;
                        q_job.byte_a       = in_data.address;
                        q_job.byte_b       = in_data.command;
                    end
                end
                FUNC_RX:
                begin
                    if (phase_reg == PH_ACK)
                    begin
                        q_push = 1'b1;
                        if (in_data.data_byte == ACK_BYTE)
                        begin
                            q_job.kind = JOB_DONE;
                            q_job.ok   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else if (tries_left_reg != '0)
                        begin
                            // the buffer CRC is unchanged, so the replay reuses it
                            tries_left_next = tries_left_reg - 1'b1;
                            q_job.kind      = JOB_REPLAY;
                            q_job.len       = CCL_LEN_W'(cmd_length_reg);
                            q_job.crc       = crc_reg;
                        end
                        else
                        begin
                            q_job.kind = JOB_DONE;
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (phase_reg == PH_READ)
                    begin
                        if (rx_index_reg < n_bytes)
                        begin
                            crc_next = fold_db;
                            if (rx_index_reg < 3'(CCL_VALUE_BYTES))
                            begin
                                value_accum_next = {value_accum_reg[23:0], in_data.data_byte};
                            end
                            else
                            begin
                                status_hold_next = in_data.data_byte;
                            end
                            rx_index_next = rx_index_reg + 1'b1;
                        end
                        else if (rx_index_reg == n_bytes)
                        begin
                            crc_high_hold_next = in_data.data_byte;
                            rx_index_next      = rx_index_reg + 1'b1;
                        end
                        else
                        begin
                            q_push = 1'b1;
                            if (crc_got == crc_reg)
                            begin
                                q_job.kind   = JOB_DONE;
                                q_job.ok     = 1'b1;
                                q_job.value  = value_accum_reg;
                                q_job.status = (saved_kind_reg == KIND_FOUR_STATUS) ?
                                               status_hold_reg : 8'h00;
                                phase_next    = PH_IDLE;
                                rx_index_next = '0;
                            end
                            else if (tries_left_reg != '0)
                            begin
                                tries_left_next  = tries_left_reg - 1'b1;
                                crc_next         = seed_saved;
                                rx_index_next    = '0;
                                value_accum_next = '0;
                                status_hold_next = '0;
                                q_job.kind       = JOB_READ;
                                q_job.byte_a     = saved_address_reg;
                                q_job.byte_b     = saved_command_reg;
                            end
                            else
                            begin
                                q_job.kind    = JOB_DONE;
                                phase_next    = PH_IDLE;
                                rx_index_next = '0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ rtl/ccl_queue.sv @@
`timescale 1ns / 1ps
// ccl_queue: short show-ahead job queue between front and back.
// Depends on ccl_pkg.
module ccl_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  ccl_pkg::job_t    push_job,
    input  logic             pop,
    output logic             empty,
    output ccl_pkg::job_t    head
);
    import ccl_pkg::*;

    localparam int PTR_W = $clog2(CCL_QUEUE_DEPTH);
    localparam int CNT_W = $clog2(CCL_QUEUE_DEPTH + 1);

    job_t             slots [CCL_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(CCL_QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CCL_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CCL_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/ccl_back.sv @@
`timescale 1ns / 1ps
// ccl_back: pops jobs, owns the command buffer and emits output beats through
// a registered output stage. Depends on ccl_pkg.
module ccl_back #(
    parameter int MAX_CMD_BYTES = ccl_pkg::CCL_MAX_CMD_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    output logic              q_pop,
    input  ccl_pkg::job_t     q_head,
    output logic              out_valid,
    input  logic              out_stall,
    output ccl_pkg::out_beat_t out_data
);
    import ccl_pkg::*;

    localparam int LEN_W = $clog2(MAX_CMD_BYTES + 1);
    localparam int IDX_W = $clog2(MAX_CMD_BYTES);

    back_state_t      state_reg, state_next;
    job_t             job_reg, job_next;
    logic [1:0]       step_reg, step_next;
    logic [LEN_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             out_valid_reg, out_valid_next;
    out_beat_t        out_data_reg, out_data_next;

    logic [7:0]       cmd_buf [MAX_CMD_BYTES];
    logic [7:0]       rd_data_reg;
    logic             buf_we;
    logic             out_load;
    logic             emit;
    out_beat_t        beat;
    out_beat_t        run_beat;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_load  = !out_valid_reg || !out_stall;

    // fixed beats of the current job, by step
    always_comb begin
        run_beat = '0;
        unique case (job_reg.kind)
            JOB_WRITE:
            begin
                run_beat.tx_valid = 1'b1;
                case (step_reg)
                    2'd0:
                    begin
                        run_beat.tx_byte = job_reg.byte_a;
                        run_beat.last    = !job_reg.with_crc;
                    end
                    2'd1:    run_beat.tx_byte = job_reg.crc[15:8];
                    default:
                    begin
                        run_beat.tx_byte = job_reg.crc[7:0];
                        run_beat.last    = 1'b1;
                    end
                endcase
            end
            JOB_READ:
            begin
                run_beat.tx_valid = 1'b1;
                run_beat.tx_byte  = (step_reg == 2'd0) ? job_reg.byte_a : job_reg.byte_b;
                run_beat.last     = (step_reg != 2'd0);
            end
            JOB_REPLAY:
            begin
                // buffer bytes already went out in FETCH/SHOW; only CRC is left
                run_beat.tx_valid = 1'b1;
                run_beat.tx_byte  = (step_reg == 2'd0) ? job_reg.crc[15:8] : job_reg.crc[7:0];
                run_beat.last     = (step_reg != 2'd0);
            end
            JOB_DONE:
            begin
                run_beat.done_res    = 1'b1;
                run_beat.success     = job_reg.ok;
                run_beat.read_value  = job_reg.value;
                run_beat.status_byte = job_reg.status;
                run_beat.last        = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        job_next       = job_reg;
        step_next      = step_reg;
        rd_cnt_next    = rd_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        buf_we         = 1'b0;
        emit           = 1'b0;
        beat           = '0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    job_next = q_head;
                    buf_we   = (q_head.kind == JOB_WRITE);
                    if (q_head.kind == JOB_REPLAY)
                    begin
                        rd_cnt_next = '0;
                        state_next  = BK_FETCH;
                    end
                    else
                    begin
                        step_next  = '0;
                        state_next = BK_RUN;
                    end
                end
            end
            BK_RUN:
            begin
                beat = run_beat;
                if (out_load)
                begin
                    emit = 1'b1;
                    if (run_beat.last)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            BK_FETCH:
            begin
                state_next = BK_SHOW;
            end
            BK_SHOW:
            begin
                beat.tx_valid = 1'b1;
                beat.tx_byte  = rd_data_reg;
                if (out_load)
                begin
                    emit = 1'b1;
                    if (LEN_W'(rd_cnt_reg + 1'b1) == job_reg.len[LEN_W-1:0])
                    begin
                        rd_cnt_next = '0;
                        step_next   = '0;
                        state_next  = BK_RUN;
                    end
                    else
                    begin
                        rd_cnt_next = rd_cnt_reg + 1'b1;
                        state_next  = BK_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = emit;
            out_data_next  = beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rd_cnt_reg    <= rd_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        job_reg      <= job_next;
        out_data_reg <= out_data_next;
    end

    // command buffer: written on pop of a write job, read one byte per fetch
    always_ff @(posedge clk) begin
        if (buf_we)
        begin
            cmd_buf[q_head.len[IDX_W-1:0]] <= q_head.byte_a;
        end
        rd_data_reg <= cmd_buf[rd_cnt_reg[IDX_W-1:0]];
    end

endmodule

@@ rtl/ccl_checker.sv @@
`timescale 1ns / 1ps
// ccl_checker: port-level assertions on the output channel of the command link,
// bound to crc_checked_command_link. Depends on ccl_pkg.
module ccl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input ccl_pkg::out_beat_t out_data
);
    import ccl_pkg::*;

    // a beat held by the sink stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out beat dropped while stalled");

    // completion and transmit never share a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.done_res && out_data.tx_valid))
        else $error("beat carries both done and tx byte");

    // completion always closes the result group of its input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> out_data.last)
        else $error("done beat not marked last");

    // failed completion reports no value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res && !out_data.success |->
            out_data.read_value == '0 && out_data.status_byte == '0)
        else $error("failed completion carries data");

endmodule

bind crc_checked_command_link ccl_checker u_ccl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);
